FILE: sv/r2fft_pkg.sv
// Package for the radix-2 real-input FFT: widths, twiddle ROM, butterfly helpers.
// No dependencies.
package r2fft_pkg;

    localparam int POINTS_DEF      = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int OUT_BITS        = 22;
    localparam int ROM_POINTS      = 64;
    localparam int TW_SHIFT        = 15;
    localparam int INDEX_BITS      = 6;

    typedef logic signed [OUT_BITS-1:0] word_t;
    typedef logic signed [16:0]         coef_t;

    function automatic coef_t quarter_cos(input logic [4:0] u);
        coef_t v;
        case (u)
            5'd0:    v = 17'sd32767;
            5'd1:    v = 17'sd32610;
            5'd2:    v = 17'sd32138;
            5'd3:    v = 17'sd31357;
            5'd4:    v = 17'sd30274;
            5'd5:    v = 17'sd28899;
            5'd6:    v = 17'sd27246;
            5'd7:    v = 17'sd25330;
            5'd8:    v = 17'sd23170;
            5'd9:    v = 17'sd20788;
            5'd10:   v = 17'sd18205;
            5'd11:   v = 17'sd15447;
            5'd12:   v = 17'sd12540;
            5'd13:   v = 17'sd9512;
            5'd14:   v = 17'sd6393;
            5'd15:   v = 17'sd3212;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    // cos(2*pi*k/64), k modulo 64
    function automatic coef_t rom_cos(input logic [5:0] u);
        coef_t v;
        if (u <= 6'd16)
            v = quarter_cos(u[4:0]);
        else if (u <= 6'd32)
            v = -quarter_cos(5'(6'd32 - u));
        else if (u <= 6'd48)
            v = -quarter_cos(5'(u - 6'd32));
        else
            v = quarter_cos(5'(7'd64 - {1'b0, u}));
        return v;
    endfunction

    function automatic word_t sat_out(input logic signed [OUT_BITS+1:0] x);
        word_t v;
        if (x > (OUT_BITS+2)'(signed'(word_t'({1'b0, {(OUT_BITS-1){1'b1}}}))))
            v = {1'b0, {(OUT_BITS-1){1'b1}}};
        else if (x < (OUT_BITS+2)'(signed'(word_t'({1'b1, {(OUT_BITS-1){1'b0}}}))))
            v = {1'b1, {(OUT_BITS-1){1'b0}}};
        else
            v = word_t'(x);
        return v;
    endfunction

endpackage

FILE: sv/r2fft_bfly.sv
// Butterfly unit: twiddle multiply with rounding, registered products, then sum/diff.
// Depends on r2fft_pkg.
module r2fft_bfly (
    input  logic                  clk,
    input  logic [5:0]            tw_idx,
    input  r2fft_pkg::word_t      er,
    input  r2fft_pkg::word_t      ei,
    input  r2fft_pkg::word_t      orr,
    input  r2fft_pkg::word_t      oi,
    output r2fft_pkg::word_t      ar,
    output r2fft_pkg::word_t      ai,
    output r2fft_pkg::word_t      br,
    output r2fft_pkg::word_t      bi
);
    localparam int PW = r2fft_pkg::OUT_BITS + 17;

    r2fft_pkg::coef_t c, s;
    logic signed [PW-1:0] p_rc, p_is, p_ic, p_rs;
    logic signed [PW-1:0] p_rc_reg, p_is_reg, p_ic_reg, p_rs_reg;
    r2fft_pkg::word_t er_reg, ei_reg;
    logic signed [PW+1:0] sr, si;
    logic signed [r2fft_pkg::OUT_BITS+1:0] tr, ti, e_r, e_i;

    assign c = r2fft_pkg::rom_cos(tw_idx);
    assign s = r2fft_pkg::rom_cos(6'(tw_idx - 6'd16));
    assign p_rc = PW'(orr) * PW'(c);
    assign p_is = PW'(oi) * PW'(s);
    assign p_ic = PW'(oi) * PW'(c);
    assign p_rs = PW'(orr) * PW'(s);

    always_ff @(posedge clk)
    begin
        p_rc_reg <= p_rc;
        p_is_reg <= p_is;
        p_ic_reg <= p_ic;
        p_rs_reg <= p_rs;
        er_reg   <= er;
        ei_reg   <= ei;
    end

    assign sr = (PW+2)'(p_rc_reg) + (PW+2)'(p_is_reg) + (PW+2)'(1 << (r2fft_pkg::TW_SHIFT-1));
    assign si = (PW+2)'(p_ic_reg) - (PW+2)'(p_rs_reg) + (PW+2)'(1 << (r2fft_pkg::TW_SHIFT-1));
    assign tr = (r2fft_pkg::OUT_BITS+2)'(sr >>> r2fft_pkg::TW_SHIFT);
    assign ti = (r2fft_pkg::OUT_BITS+2)'(si >>> r2fft_pkg::TW_SHIFT);
    assign e_r = (r2fft_pkg::OUT_BITS+2)'(er_reg);
    assign e_i = (r2fft_pkg::OUT_BITS+2)'(ei_reg);

    assign ar = r2fft_pkg::sat_out(e_r + tr);
    assign ai = r2fft_pkg::sat_out(e_i + ti);
    assign br = r2fft_pkg::sat_out(e_r - tr);
    assign bi = r2fft_pkg::sat_out(e_i - ti);
endmodule

FILE: sv/radix2_fft_real_input.sv
// Radix-2 DIT FFT of a real frame: samples load one per accepted cycle in bit-reversed order.
// On frame_end the points not loaded are zero-filled, one per cycle, before the compute starts.
// One shared butterfly then runs (POINTS/2)*log2(POINTS) butterflies, each in three steps
// (register read, product, writeback). A fetch step follows, then all POINTS bins are emitted
// in order, one per accepted cycle. The input is not ready from frame_end to the last bin.
// Depends on r2fft_pkg and r2fft_bfly.
module radix2_fft_real_input #(
    parameter int POINTS      = r2fft_pkg::POINTS_DEF,
    parameter int SAMPLE_BITS = r2fft_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         sample_value,
    input  logic                                  frame_end,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [r2fft_pkg::INDEX_BITS-1:0]      bin_index,
    output logic signed [r2fft_pkg::OUT_BITS-1:0] real_part,
    output logic signed [r2fft_pkg::OUT_BITS-1:0] imag_part,
    output logic                                  last_bin,
    output logic                                  truncated
);
    localparam int LG = $clog2(POINTS);
    localparam int AW = (LG < 1) ? 1 : LG;
    localparam int HALF = POINTS / 2;
    localparam int TWS = r2fft_pkg::ROM_POINTS / POINTS;

    typedef enum logic [2:0] {S_LOAD, S_CLEAR, S_RD, S_MUL, S_WR, S_FETCH, S_EMIT} state_t;

    state_t state_reg;
    logic [AW:0] load_count_reg;
    logic overflow_seen_reg;
    logic [AW-1:0] idx_reg;
    logic [$clog2(AW+1)-1:0] stage_reg;
    logic [AW-1:0] bf_reg;

    r2fft_pkg::word_t re_mem [POINTS];
    r2fft_pkg::word_t im_mem [POINTS];

    r2fft_pkg::word_t er_reg, ei_reg, or_reg, oi_reg;
    r2fft_pkg::word_t real_part_reg, imag_part_reg;
    r2fft_pkg::word_t ar, ai, br, bi;
    logic [5:0] tw_idx_reg;
    logic [AW-1:0] ea_reg, oa_reg;
    logic [AW-1:0] ea, oa, wr_rev;
    logic [AW:0] half_s;
    logic [5:0] tw_idx;
    logic [2*AW:0] kk;

    always_comb
    begin
        wr_rev = '0;
        for (int b = 0; b < LG; b++)
            wr_rev[LG-1-b] = load_count_reg[b];
    end

    // butterfly addresses: half = 2^stage, k = bf mod half, group = bf / half
    assign half_s = (AW+1)'(1) << stage_reg;
    always_comb
    begin
        kk = (2*AW+1)'(bf_reg & AW'(half_s - 1'b1));
        ea = AW'(((bf_reg >> stage_reg) << (stage_reg + 1)) | AW'(kk));
        oa = AW'(ea | AW'(half_s));
        tw_idx = 6'((kk * (2*AW+1)'(TWS)) << (LG - 1 - stage_reg));
    end

    r2fft_bfly u_bfly (
        .clk(clk), .tw_idx(tw_idx_reg),
        .er(er_reg), .ei(ei_reg), .orr(or_reg), .oi(oi_reg),
        .ar(ar), .ai(ai), .br(br), .bi(bi)
    );

    assign in_ready = (state_reg == S_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_LOAD;
            load_count_reg    <= '0;
            overflow_seen_reg <= 1'b0;
            idx_reg           <= '0;
            stage_reg         <= '0;
            bf_reg            <= '0;
            out_valid         <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                    if (in_valid)
                    begin
                        if (load_count_reg < (AW+1)'(POINTS))
                            load_count_reg <= load_count_reg + 1'b1;
                        else
                            overflow_seen_reg <= 1'b1;
                        if (frame_end)
                        begin
                            state_reg <= S_CLEAR;
                            if (load_count_reg < (AW+1)'(POINTS))
                                load_count_reg <= load_count_reg + 1'b1;
                        end
                    end
                S_CLEAR:
                    if (load_count_reg >= (AW+1)'(POINTS))
                    begin
                        state_reg <= S_RD;
                        stage_reg <= '0;
                        bf_reg    <= '0;
                    end
                    else
                        load_count_reg <= load_count_reg + 1'b1;
                S_RD:  state_reg <= S_MUL;
                S_MUL: state_reg <= S_WR;
                S_WR:
                    if (bf_reg == AW'(HALF - 1))
                    begin
                        bf_reg <= '0;
                        if (stage_reg == ($bits(stage_reg))'(LG - 1))
                        begin
                            state_reg <= S_FETCH;
                            idx_reg   <= '0;
                        end
                        else
                        begin
                            stage_reg <= stage_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        bf_reg    <= bf_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                S_FETCH:
                begin
                    state_reg <= S_EMIT;
                    out_valid <= 1'b1;
                end
                S_EMIT:
                    if (out_ready)
                    begin
                        if (idx_reg == AW'(POINTS - 1))
                        begin
                            out_valid         <= 1'b0;
                            state_reg         <= S_LOAD;
                            load_count_reg    <= '0;
                            overflow_seen_reg <= 1'b0;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    // datapath: memory writes and reads
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_LOAD && in_valid && load_count_reg < (AW+1)'(POINTS)) ||
            (state_reg == S_CLEAR && load_count_reg < (AW+1)'(POINTS)))
        begin
            re_mem[wr_rev] <= (state_reg == S_LOAD) ?
                r2fft_pkg::OUT_BITS'(sample_value) : '0;
            im_mem[wr_rev] <= '0;
        end
        if (state_reg == S_RD)
        begin
            er_reg     <= re_mem[ea];
            ei_reg     <= im_mem[ea];
            or_reg     <= re_mem[oa];
            oi_reg     <= im_mem[oa];
            ea_reg     <= ea;
            oa_reg     <= oa;
            tw_idx_reg <= tw_idx;
        end
        if (state_reg == S_WR)
        begin
            re_mem[ea_reg] <= ar;
            im_mem[ea_reg] <= ai;
            re_mem[oa_reg] <= br;
            im_mem[oa_reg] <= bi;
        end
        if (state_reg == S_FETCH)
        begin
            real_part_reg <= re_mem[idx_reg];
            imag_part_reg <= im_mem[idx_reg];
        end
        if (state_reg == S_EMIT && out_ready)
        begin
            real_part_reg <= re_mem[AW'(idx_reg + 1'b1)];
            imag_part_reg <= im_mem[AW'(idx_reg + 1'b1)];
        end
    end

    assign bin_index = r2fft_pkg::INDEX_BITS'(idx_reg);
    assign real_part = real_part_reg;
    assign imag_part = imag_part_reg;
    assign last_bin  = (idx_reg == AW'(POINTS - 1));
    assign truncated = overflow_seen_reg;

`ifndef SYNTHESIS
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input ready during emit");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= (AW+1)'(POINTS)) else $error("load count overran");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_bin |=> !out_valid && in_ready)
        else $error("emit did not end after last bin");
`endif
endmodule

FILE: test/radix2_fft_real_input_tb.sv
// Testbench for radix2_fft_real_input: random and directed real frames, bins checked
// against a fixed-point DIT FFT predictor. Depends on r2fft_pkg and the block's RTL.
module radix2_fft_real_input_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPT = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               fend;
    } sample_item_t;

    typedef struct packed {
        logic [5:0]         idx;
        logic signed [21:0] re;
        logic signed [21:0] im;
        logic               last;
        logic               trunc;
    } bin_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] sample_value = '0;
    logic frame_end = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [5:0] bin_index;
    logic signed [21:0] real_part, imag_part;
    logic last_bin, truncated;

    sample_item_t pending_samples[$];
    bin_t expected_bins[$];
    longint fft_re[NPT];
    longint fft_im[NPT];
    int frame_len = 0;
    bit frame_trunc = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int in_gap = 0;
    int out_gap = 0;
    bit stim_done = 0;

    radix2_fft_real_input i_dut (.*);

    always #5 clk = ~clk;

    function automatic longint tw_cos(int k);
        int qc[17] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
                       20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
        int u;
        u = k & 63;
        if (u <= 16) return qc[u];
        if (u <= 32) return -qc[32 - u];
        if (u <= 48) return -qc[u - 32];
        return qc[64 - u];
    endfunction

    function automatic longint clip22(longint x);
        if (x > 2097151) return 2097151;
        if (x < -2097152) return -2097152;
        return x;
    endfunction

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic predict_frame();
        longint tr, ti, er, ei, c, s;
        int r, half, step;
        for (int i = 0; i < NPT; i++) begin
            r = 0;
            for (int b = 0; b < 6; b++) r |= ((i >> b) & 1) << (5 - b);
            if (r > i) begin
                tr = fft_re[i]; fft_re[i] = fft_re[r]; fft_re[r] = tr;
                ti = fft_im[i]; fft_im[i] = fft_im[r]; fft_im[r] = ti;
            end
        end
        for (int len = 2; len <= NPT; len <<= 1) begin
            half = len >> 1;
            step = 64 / len;
            for (int j = 0; j < NPT; j += len) begin
                for (int k = 0; k < half; k++) begin
                    c = tw_cos(k * step);
                    s = tw_cos(k * step - 16);
                    tr = (fft_re[j+k+half] * c + fft_im[j+k+half] * s + 16384) >>> 15;
                    ti = (fft_im[j+k+half] * c - fft_re[j+k+half] * s + 16384) >>> 15;
                    er = fft_re[j+k];
                    ei = fft_im[j+k];
                    fft_re[j+k] = clip22(er + tr);
                    fft_im[j+k] = clip22(ei + ti);
                    fft_re[j+k+half] = clip22(er - tr);
                    fft_im[j+k+half] = clip22(ei - ti);
                end
            end
        end
        for (int k = 0; k < NPT; k++)
            expected_bins.push_back('{6'(k), 22'(fft_re[k]), 22'(fft_im[k]),
                                      k == NPT - 1, frame_trunc});
        for (int k = 0; k < NPT; k++) begin
            fft_re[k] = 0;
            fft_im[k] = 0;
        end
        frame_len = 0;
        frame_trunc = 0;
    endtask

    task automatic accept_sample(sample_item_t it);
        if (frame_len < NPT) begin
            fft_re[frame_len] = it.sample;
            fft_im[frame_len] = 0;
            frame_len++;
        end else begin
            frame_trunc = 1;
        end
        if (it.fend) predict_frame();
    endtask

    task automatic queue_frame(int len, int kind);
        sample_item_t it;
        for (int i = 0; i < len; i++) begin
            case (kind)
                0: it.sample = 16'($urandom);
                1: it.sample = 16'sh7fff;
                2: it.sample = 16'sh8000;
                3: it.sample = (i % 2) ? 16'sh8000 : 16'sh7fff;
                default: it.sample = 16'($urandom_range(0, 255)) - 16'sd128;
            endcase
            it.fend = (i == len - 1);
            pending_samples.push_back(it);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                accept_sample('{sample_value, frame_end});
                void'(pending_samples.pop_front());
                in_gap = rand_gap();
            end
            if (!(in_valid && !in_ready)) begin
                if (pending_samples.size() > 0 && in_gap == 0 &&
                    !(in_valid && in_ready && pending_samples.size() == 0)) begin
                    in_valid <= 1'b1;
                    sample_value <= pending_samples[0].sample;
                    frame_end <= pending_samples[0].fend;
                end else begin
                    in_valid <= 1'b0;
                    if (in_gap > 0) in_gap--;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_bins.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected bin %0d", bin_index);
                end else if (expected_bins[0] !==
                             {bin_index, real_part, imag_part, last_bin, truncated}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("bin mismatch: exp idx=%0d re=%0d im=%0d last=%0b tr=%0b, got idx=%0d re=%0d im=%0d last=%0b tr=%0b",
                            expected_bins[0].idx, expected_bins[0].re, expected_bins[0].im,
                            expected_bins[0].last, expected_bins[0].trunc,
                            bin_index, real_part, imag_part, last_bin, truncated);
                end
                if (expected_bins.size() > 0) void'(expected_bins.pop_front());
            end
            if (out_gap > 0) begin
                out_ready <= 1'b0;
                out_gap--;
            end else begin
                out_ready <= 1'b1;
                out_gap = rand_gap();
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    initial begin
        int n;
        // directed: overlong full-scale, single-sample, short alternating frames
        queue_frame(66, 1);
        queue_frame(1, 2);
        queue_frame(5, 3);
        n = 72;
        while (n < 120) begin
            int len;
            case ($urandom_range(0, 1))
                0: len = $urandom_range(1, 8);
                default: len = $urandom_range(9, 20);
            endcase
            queue_frame(len, ($urandom_range(0, 3) == 0) ? 4 : 0);
            n += len;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_samples.size() > 0 || expected_bins.size() > 0) begin
            @(posedge clk);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("radix2_fft_real_input_tb failed");
                $finish;
            end
        end
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_bins.size() == 0)
            $display("radix2_fft_real_input_tb passed");
        else
            $display("radix2_fft_real_input_tb failed");
        $finish;
    end
endmodule

FILE: radix2_fft_real_input.f
sv/r2fft_pkg.sv
sv/r2fft_bfly.sv
sv/radix2_fft_real_input.sv
test/radix2_fft_real_input_tb.sv
